>>> rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, widths and command codes of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CMD_BITS   = 2;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_BITS-1:0]          count_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic   insert_en;
        logic   delete_en;
        value_t key;
    } cell_ctl_t;

endpackage

>>> rtl/sorted_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Bounded sorted multiset held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// result: registered in the output register in the cycle after the input transfer
// throughput: one command per cycle while the output register is empty or being taken; the key
//   is broadcast to all cells and the whole row compares and shifts in that same cycle
// reset clears the entry count, all cell valid bits and the output valid flag;
//   the row needs no clearing pass and takes commands right after reset
module sorted_list_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // present[0], refused[1], entry_count[8:2], zero[15:9]
);

    localparam int N = sle_pkg::CAPACITY;

    sle_pkg::value_t    entry_vec [N];
    logic [N-1:0]       valid_vec;
    logic [N-1:0]       ge_vec;
    logic [N-1:0]       eq_vec;
    sle_pkg::cell_ctl_t ctl;

    sle_pkg::count_t    count_reg;
    sle_pkg::count_t    count_next;
    logic               out_valid_reg;
    logic               present_reg;
    logic               present_next;
    logic               refused_reg;
    logic               refused_next;

    logic               accept;
    logic               full;
    logic               found;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == sle_pkg::count_t'(N));
    assign found    = |eq_vec;

    always_comb
    begin
        ctl.key       = sle_pkg::value_t'(s_tdata[sle_pkg::VALUE_BITS-1:0]);
        ctl.insert_en = 1'b0;
        ctl.delete_en = 1'b0;
        count_next    = count_reg;
        present_next  = 1'b0;
        refused_next  = 1'b0;
        if (accept)
        begin
            unique case (s_tuser)
                sle_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        ctl.insert_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                sle_pkg::CMD_DELETE:
                begin
                    present_next = found;
                    if (found)
                    begin
                        ctl.delete_en = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
                sle_pkg::CMD_SEARCH:
                begin
                    present_next = found;
                end
                default:
                begin
                    present_next = 1'b0;
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            sle_pkg::value_t l_entry;
            sle_pkg::value_t r_entry;
            logic            l_valid;
            logic            l_ge;
            logic            r_valid;

            if (i == 0)
            begin : g_first
                assign l_entry = '0;
                assign l_valid = 1'b1;
                assign l_ge    = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_entry = entry_vec[i-1];
                assign l_valid = valid_vec[i-1];
                assign l_ge    = ge_vec[i-1];
            end

            if (i == N - 1)
            begin : g_last
                assign r_entry = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_entry = entry_vec[i+1];
                assign r_valid = valid_vec[i+1];
            end

            sle_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_entry  (l_entry),
                .left_valid  (l_valid),
                .left_ge     (l_ge),
                .right_entry (r_entry),
                .right_valid (r_valid),
                .entry       (entry_vec[i]),
                .valid       (valid_vec[i]),
                .ge          (ge_vec[i]),
                .eq          (eq_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            present_reg <= present_next;
            refused_reg <= refused_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - 2 - sle_pkg::CNT_BITS){1'b0}}, count_reg, refused_reg,
                       present_reg};

    // count always equals the number of occupied cells
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count differs from occupied cells");

    // occupied cells form a contiguous run from cell zero
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in occupied cells");

    // a refused insert is only reported with a full store
    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && refused_reg) |-> (count_reg == sle_pkg::count_t'(N)))
        else $error("insert refused below capacity");

    // an insert and a delete never reach the cells together
    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.insert_en && ctl.delete_en))
        else $error("insert and delete shift at once");

endmodule

>>> rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted row: holds an entry and its valid bit, compares it
// with the broadcast key and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module sle_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sle_pkg::cell_ctl_t ctl,
    input  sle_pkg::value_t    left_entry,
    input  logic               left_valid,
    input  logic               left_ge,
    input  sle_pkg::value_t    right_entry,
    input  logic               right_valid,
    output sle_pkg::value_t    entry,
    output logic               valid,
    output logic               ge,
    output logic               eq
);

    sle_pkg::value_t entry_reg;
    sle_pkg::value_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign ge    = valid_reg && (entry_reg >= ctl.key);
    assign eq    = valid_reg && (entry_reg == ctl.key);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.insert_en)
        begin
            // cells from the insert point on move one place right
            if (left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge || !valid_reg)
            begin
                entry_next = ctl.key;
            end
            valid_next = left_valid;
        end
        else if (ctl.delete_en)
        begin
            // first match and everything after it pull from the right
            if (ge)
            begin
                entry_next = right_entry;
            end
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule
